>>> hw/rtl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Opcodes, request kinds and status codes of the stack bytecode executor.
// ----------------------------------------------------------------------------
package sbe_pkg;

    // request kinds
    localparam logic [1:0] REQ_WR_PROG = 2'd0;
    localparam logic [1:0] REQ_WR_VAR  = 2'd1;
    localparam logic [1:0] REQ_RD_VAR  = 2'd2;
    localparam logic [1:0] REQ_RUN     = 2'd3;

    // instruction words
    localparam logic [31:0] OPC_ADD   = 32'd0;
    localparam logic [31:0] OPC_MULT  = 32'd1;
    localparam logic [31:0] OPC_EQ    = 32'd12;
    localparam logic [31:0] OPC_LS    = 32'd13;
    localparam logic [31:0] OPC_SUB   = 32'd66;
    localparam logic [31:0] OPC_NEG   = 32'd67;
    localparam logic [31:0] OPC_GT    = 32'd68;
    localparam logic [31:0] OPC_OR    = 32'd69;
    localparam logic [31:0] OPC_NOT   = 32'd70;
    localparam logic [31:0] OPC_PUSHI = 32'd100;
    localparam logic [31:0] OPC_PUSH  = 32'd101;
    localparam logic [31:0] OPC_POP   = 32'd102;
    localparam logic [31:0] OPC_JF    = 32'd200;
    localparam logic [31:0] OPC_J     = 32'd201;
    localparam logic [31:0] OPC_AND   = 32'd300;
    localparam logic [31:0] OPC_HALT  = 32'd400;

    // result status
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_LIMIT = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_BADOP = 3'd4;
    localparam logic [2:0] ST_PCR   = 3'd5;
    localparam logic [2:0] ST_IDX   = 3'd6;

    localparam logic [23:0] STEP_LIMIT_RST = 24'd65536;

    typedef struct packed {
        logic [31:0] value;
        logic [8:0]  addr;
        logic [1:0]  op;
    } req_t;

    typedef struct packed {
        logic [8:0]  final_pc;
        logic [31:0] read_value;
        logic [2:0]  status;
    } rsp_t;

endpackage

>>> hw/rtl/stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// Stack machine that stores a program and I/O variables and runs the program.
// ----------------------------------------------------------------------------
//  channel   direction  word
//  s_axis    in         op, addr, value (request)
//  m_axis    out        status, read_value, final_pc (result)
//  cfg       in         step_limit (24 bits)
//
//  Program writes and variable writes are answered from S_IDLE, variable reads
//  pass through S_RDV. A run passes S_FETCH and S_DECODE per instruction and
//  adds S_ARG for an instruction with an operand word and S_VAR for a variable
//  push; the program memory has a single read port, so operands need S_ARG.
//  After reset a clearing pass over max(PROG_DEPTH, VAR_DEPTH) addresses zeroes
//  the program and variable memories; no request is taken meanwhile.
//  One request is in flight at a time; a new one is taken once the result
//  register is free or being drained, so a stalled m_axis stalls s_axis.
// ----------------------------------------------------------------------------
module stack_bytecode_executor #(
    parameter int PROG_DEPTH  = 512,
    parameter int VAR_DEPTH   = 128,
    parameter int STACK_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[1:0], addr[10:2], value[42:11], zero[47:43]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], read_value[34:3], final_pc[43:35], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);
    import sbe_pkg::*;

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int PCW = PAW + 1;
    localparam int VAW = $clog2(VAR_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CLR_N = (PROG_DEPTH > VAR_DEPTH) ? PROG_DEPTH : VAR_DEPTH;
    localparam int CLW = $clog2(CLR_N + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_DECODE = 3'd3;
    localparam logic [2:0] S_ARG    = 3'd4;
    localparam logic [2:0] S_VAR    = 3'd5;
    localparam logic [2:0] S_RDV    = 3'd6;

    // memories
    logic [31:0] prog_mem [PROG_DEPTH];
    logic [31:0] var_mem  [VAR_DEPTH];
    logic [31:0] stk_mem  [STACK_DEPTH];
    logic [31:0] prog_rdata_reg, var_rdata_reg, stk_rdata_reg;

    logic            pw_en, vw_en, sw_en;
    logic [PAW-1:0]  pw_addr, pr_addr;
    logic [VAW-1:0]  vw_addr, vr_addr;
    logic [SAW-1:0]  sw_addr, sr_addr;
    logic [31:0]     pw_data, vw_data, sw_data;

    // control and datapath registers
    logic [2:0]      state_reg, state_next;
    logic [CLW-1:0]  clr_reg, clr_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [23:0]     steps_reg, steps_next;
    logic [23:0]     limit_reg;
    logic [31:0]     top_reg, top_next;
    logic [31:0]     opw_reg, opw_next;
    logic            m_valid_reg, m_valid_next;
    rsp_t            rsp_reg, rsp_next;

    req_t            req;
    logic            s_acc;
    logic            fin;
    logic [2:0]      fin_st;
    logic [31:0]     opw, arg, nxt, alu;
    logic [31:0]     pc32, pc1_32, addr32;
    logic            take;

    assign req       = req_t'(s_tdata[42:0]);
    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'd0, rsp_reg};

    assign opw    = prog_rdata_reg;
    assign arg    = prog_rdata_reg;
    assign nxt    = stk_rdata_reg;
    assign pc32   = 32'(pc_reg);
    assign pc1_32 = pc32 + 32'd1;
    assign addr32 = 32'(req.addr);

    // the second stack entry is always read, so it is ready in decode
    assign sr_addr = SAW'(sp_reg - SPW'(2));

    always_comb begin
        case (opw)
            OPC_ADD:  alu = top_reg + nxt;
            OPC_MULT: alu = top_reg * nxt;
            OPC_EQ:   alu = {31'd0, nxt == top_reg};
            OPC_LS:   alu = {31'd0, $signed(top_reg) < $signed(nxt)};
            OPC_SUB:  alu = top_reg - nxt;
            OPC_GT:   alu = {31'd0, $signed(nxt) < $signed(top_reg)};
            OPC_OR:   alu = {31'd0, (nxt != 32'd0) || (top_reg != 32'd0)};
            OPC_NEG:  alu = 32'd0 - top_reg;
            OPC_NOT:  alu = {31'd0, top_reg == 32'd0};
            default:  alu = {31'd0, (nxt != 32'd0) && (top_reg != 32'd0)};
        endcase
        take = (opw_reg == OPC_J) ? (top_reg == 32'd1) : (top_reg != 32'd1);
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        pc_next      = pc_reg;
        sp_next      = sp_reg;
        steps_next   = steps_reg;
        top_next     = top_reg;
        opw_next     = opw_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rsp_next     = rsp_reg;
        fin          = 1'b0;
        fin_st       = ST_OK;
        pw_en = 1'b0; pw_addr = PAW'(req.addr); pw_data = req.value;
        vw_en = 1'b0; vw_addr = VAW'(req.addr); vw_data = req.value;
        sw_en = 1'b0; sw_addr = SAW'(sp_reg - SPW'(1)); sw_data = top_reg;
        pr_addr = pc_reg[PAW-1:0];
        vr_addr = VAW'(req.addr);

        case (state_reg)
            S_CLEAR: begin
                // sweep both memories with zeros
                pw_addr = PAW'(clr_reg);
                pw_data = 32'd0;
                pw_en   = 32'(clr_reg) < PROG_DEPTH;
                vw_addr = VAW'(clr_reg);
                vw_data = 32'd0;
                vw_en   = 32'(clr_reg) < VAR_DEPTH;
                clr_next = clr_reg + CLW'(1);
                if (32'(clr_reg) == CLR_N - 1) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) begin
                    rsp_next.status     = ST_OK;
                    rsp_next.read_value = 32'd0;
                    rsp_next.final_pc   = 9'd0;
                    case (req.op)
                        REQ_WR_PROG: begin
                            m_valid_next = 1'b1;
                            if (addr32 < PROG_DEPTH) pw_en = 1'b1;
                            else rsp_next.status = ST_PCR;
                        end
                        REQ_WR_VAR: begin
                            m_valid_next = 1'b1;
                            if (addr32 < VAR_DEPTH) vw_en = 1'b1;
                            else rsp_next.status = ST_IDX;
                        end
                        REQ_RD_VAR: begin
                            if (addr32 < VAR_DEPTH) state_next = S_RDV;
                            else begin
                                m_valid_next    = 1'b1;
                                rsp_next.status = ST_IDX;
                            end
                        end
                        default: begin
                            pc_next    = '0;
                            sp_next    = '0;
                            steps_next = '0;
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_RDV: begin
                m_valid_next        = 1'b1;
                rsp_next.read_value = var_rdata_reg;
                state_next          = S_IDLE;
            end
            S_FETCH: begin
                if (pc32 >= PROG_DEPTH) begin
                    fin = 1'b1; fin_st = ST_PCR;
                end else state_next = S_DECODE;
            end
            S_DECODE: begin
                opw_next = opw;
                pr_addr  = PAW'(pc1_32);
                state_next = S_FETCH;
                if (opw == OPC_HALT) begin
                    fin = 1'b1; fin_st = ST_OK;
                end else if (steps_reg >= limit_reg) begin
                    fin = 1'b1; fin_st = ST_LIMIT;
                end else begin
                    case (opw)
                        OPC_PUSHI, OPC_PUSH, OPC_POP, OPC_JF, OPC_J: begin
                            if (pc1_32 >= PROG_DEPTH) begin
                                fin = 1'b1; fin_st = ST_PCR;
                            end else state_next = S_ARG;
                        end
                        OPC_NEG, OPC_NOT: begin
                            if (sp_reg < SPW'(1)) begin
                                fin = 1'b1; fin_st = ST_UNDER;
                            end else begin
                                top_next   = alu;
                                pc_next    = pc_reg + PCW'(1);
                                steps_next = steps_reg + 24'd1;
                            end
                        end
                        OPC_ADD, OPC_MULT, OPC_EQ, OPC_LS, OPC_SUB,
                        OPC_GT, OPC_OR, OPC_AND: begin
                            if (sp_reg < SPW'(2)) begin
                                fin = 1'b1; fin_st = ST_UNDER;
                            end else begin
                                top_next   = alu;
                                sp_next    = sp_reg - SPW'(1);
                                pc_next    = pc_reg + PCW'(1);
                                steps_next = steps_reg + 24'd1;
                            end
                        end
                        default: begin
                            fin = 1'b1; fin_st = ST_BADOP;
                        end
                    endcase
                end
            end
            S_ARG: begin
                vr_addr    = VAW'(arg);
                state_next = S_FETCH;
                case (opw_reg)
                    OPC_PUSHI: begin
                        if (32'(sp_reg) >= STACK_DEPTH) begin
                            fin = 1'b1; fin_st = ST_OVER;
                        end else begin
                            sw_en      = sp_reg != '0;
                            top_next   = arg;
                            sp_next    = sp_reg + SPW'(1);
                            pc_next    = pc_reg + PCW'(2);
                            steps_next = steps_reg + 24'd1;
                        end
                    end
                    OPC_PUSH: begin
                        if (arg >= VAR_DEPTH) begin
                            fin = 1'b1; fin_st = ST_IDX;
                        end else if (32'(sp_reg) >= STACK_DEPTH) begin
                            fin = 1'b1; fin_st = ST_OVER;
                        end else state_next = S_VAR;
                    end
                    OPC_POP: begin
                        if (arg >= VAR_DEPTH) begin
                            fin = 1'b1; fin_st = ST_IDX;
                        end else if (sp_reg < SPW'(1)) begin
                            fin = 1'b1; fin_st = ST_UNDER;
                        end else begin
                            vw_en      = 1'b1;
                            vw_addr    = VAW'(arg);
                            vw_data    = top_reg;
                            top_next   = nxt;
                            sp_next    = sp_reg - SPW'(1);
                            pc_next    = pc_reg + PCW'(2);
                            steps_next = steps_reg + 24'd1;
                        end
                    end
                    default: begin
                        // conditional jumps keep the stack
                        if (sp_reg < SPW'(1)) begin
                            fin = 1'b1; fin_st = ST_UNDER;
                        end else if (take && (arg >= PROG_DEPTH)) begin
                            fin = 1'b1; fin_st = ST_PCR;
                        end else begin
                            pc_next    = take ? PCW'(arg) : pc_reg + PCW'(2);
                            steps_next = steps_reg + 24'd1;
                        end
                    end
                endcase
            end
            S_VAR: begin
                sw_en      = sp_reg != '0;
                top_next   = var_rdata_reg;
                sp_next    = sp_reg + SPW'(1);
                pc_next    = pc_reg + PCW'(2);
                steps_next = steps_reg + 24'd1;
                state_next = S_FETCH;
            end
            default: state_next = S_IDLE;
        endcase

        if (fin) begin
            m_valid_next        = 1'b1;
            rsp_next.status     = fin_st;
            rsp_next.read_value = 32'd0;
            rsp_next.final_pc   = pc32[8:0];
            state_next          = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (pw_en) prog_mem[pw_addr] <= pw_data;
        prog_rdata_reg <= prog_mem[pr_addr];
    end

    always_ff @(posedge aclk) begin
        if (vw_en) var_mem[vw_addr] <= vw_data;
        var_rdata_reg <= var_mem[vr_addr];
    end

    always_ff @(posedge aclk) begin
        if (sw_en) stk_mem[sw_addr] <= sw_data;
        stk_rdata_reg <= stk_mem[sr_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= STEP_LIMIT_RST;
            sp_reg      <= '0;
            pc_reg      <= '0;
            steps_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            sp_reg      <= sp_next;
            pc_reg      <= pc_next;
            steps_reg   <= steps_next;
            if (cfg_valid) limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        opw_reg <= opw_next;
        rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sp_reg) <= STACK_DEPTH)
        else $error("stack pointer beyond depth");
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (m_tvalid || (state_reg != S_IDLE)))
        else $error("request taken without a result or busy state");
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!s_tready && !m_tvalid))
        else $error("activity during clearing pass");
    a_steps_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (steps_reg <= limit_reg))
        else $error("step count beyond limit");
`endif

endmodule
